### src/lpm_pkg.sv
package lpm_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_DISC,
    ST_TICK,
    ST_RESP
  } state_t;

  // request kinds carried on s_axis_tuser
  localparam logic [2:0] REQ_DISCOVER = 3'd0;
  localparam logic [2:0] REQ_REQUEST  = 3'd1;
  localparam logic [2:0] REQ_RENEW    = 3'd2;
  localparam logic [2:0] REQ_RELEASE  = 3'd3;
  localparam logic [2:0] REQ_TICK     = 3'd4;

  // reply status carried on m_axis_tuser
  localparam logic [3:0] STS_OFFER        = 4'd0;
  localparam logic [3:0] STS_ACK_NEW      = 4'd1;
  localparam logic [3:0] STS_ACK_RENEW    = 4'd2;
  localparam logic [3:0] STS_NONE_FREE    = 4'd3;
  localparam logic [3:0] STS_OUT_OF_RANGE = 4'd4;
  localparam logic [3:0] STS_ALREADY      = 4'd5;
  localparam logic [3:0] STS_RELEASED     = 4'd6;
  localparam logic [3:0] STS_RELEASE_MISS = 4'd7;
  localparam logic [3:0] STS_RENEW_MISS   = 4'd8;
  localparam logic [3:0] STS_TICK_DONE    = 4'd9;

  // configuration register indexes
  localparam logic [1:0] CFG_RANGE_START = 2'd0;
  localparam logic [1:0] CFG_POOL_SIZE   = 2'd1;
  localparam logic [1:0] CFG_LEASE_LEN   = 2'd2;

  localparam logic [31:0] RESET_RANGE_START = 32'd3222339587;
  localparam logic [4:0]  RESET_POOL_SIZE   = 5'd10;
  localparam logic [15:0] RESET_LEASE_LEN   = 16'd20;

  // one lease slot in the slot memory
  typedef struct packed {
    logic [47:0] hw_addr;
    logic [31:0] expiry;
  } entry_t;

endpackage

### src/lpm_ram.sv
module lpm_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ip_lease_pool_manager_core.sv
// channel   dir  width  contents
// s_axis    in   112    tdata: ip_addr, client_hw_addr, transaction_id; tuser: req_type
// m_axis    out  72     tdata: assigned_ip, echo_transaction_id, expired_count; tuser: status
// cfg       in   32     cfg_addr: range_start, pool_size, lease length
//
// one request at a time; request goes straight to the reply, renew and release
// first read the slot memory, but not when the address lies past the last slot,
// discover walks the valid bits one slot a cycle, tick sweeps the slot memory
// one entry a cycle and compares each entry in the cycle after its read.
// a finished reply sits in the output register while the next request is taken;
// while that register is still held, the next reply waits and input stays stalled.
// reset clears all lease valid bits and the seconds counter and loads the reset configuration at once.
module ip_lease_pool_manager_core #(
  parameter int POOL_MAX = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [111:0]  s_axis_tdata,   // ip_addr, client_hw_addr, transaction_id
  input  logic [2:0]    s_axis_tuser,   // req_type
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [71:0]   m_axis_tdata,   // assigned_ip, echo_transaction_id, expired_count
  output logic [3:0]    m_axis_tuser,   // status
  input  logic          cfg_we,
  input  logic [1:0]    cfg_addr,
  input  logic [31:0]   cfg_data
);

  localparam int IDX_W = (POOL_MAX > 1) ? $clog2(POOL_MAX) : 1;
  localparam int CNT_W = $clog2(POOL_MAX + 1);
  localparam logic [31:0] POOL_MAX_W = 32'(POOL_MAX);

  lpm_pkg::state_t state, state_next;

  logic [31:0] range_start;
  logic [4:0]  pool_size;
  logic [15:0] lease_len;
  logic [31:0] now;
  logic [POOL_MAX-1:0] valid;

  logic [2:0]       req;
  logic [31:0]      ip;
  logic [47:0]      hw;
  logic [31:0]      xid;
  logic [IDX_W-1:0] slot;
  logic [CNT_W-1:0] cnt;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic [CNT_W-1:0] exp_cnt;
  logic [3:0]       res_status;
  logic [31:0]      res_ip;

  logic [31:0]      eff_size;
  logic [31:0]      in_ip;
  logic [47:0]      in_hw;
  logic [31:0]      in_xid;
  logic [31:0]      in_off;
  logic [IDX_W-1:0] in_idx;
  logic             s_hs;
  logic             out_free;
  logic [32:0]      exp_sum;
  logic [31:0]      expiry_new;
  logic             hit;
  logic             cnt_done;
  logic [IDX_W-1:0] cnt_idx;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  lpm_pkg::entry_t  ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  lpm_pkg::entry_t  ram_rdata;

  assign eff_size = (32'(pool_size) < POOL_MAX_W) ? 32'(pool_size) : POOL_MAX_W;
  assign in_ip    = s_axis_tdata[31:0];
  assign in_hw    = s_axis_tdata[79:32];
  assign in_xid   = s_axis_tdata[111:80];
  assign in_off   = in_ip - range_start;
  assign in_idx   = in_off[IDX_W-1:0];
  assign s_axis_tready = (state == lpm_pkg::ST_IDLE);
  assign s_hs     = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  // lease end saturates at the top of the counter
  assign exp_sum    = {1'b0, now} + 33'(lease_len);
  assign expiry_new = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
  assign hit      = valid[slot] && (ram_rdata.hw_addr == hw);
  assign cnt_done = (32'(cnt) >= POOL_MAX_W);
  assign cnt_idx  = cnt[IDX_W-1:0];

  lpm_ram #(
    .WIDTH ($bits(lpm_pkg::entry_t)),
    .DEPTH (POOL_MAX)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = in_idx;
    ram_wdata  = '{hw_addr: in_hw, expiry: expiry_new};
    ram_raddr  = in_idx;
    case (state)
      lpm_pkg::ST_IDLE: begin
        if (s_hs) begin
          case (s_axis_tuser)
            lpm_pkg::REQ_DISCOVER: state_next = lpm_pkg::ST_DISC;
            lpm_pkg::REQ_REQUEST: begin
              state_next = lpm_pkg::ST_RESP;
              if (in_off < eff_size && !valid[in_idx]) begin
                ram_we = 1'b1;
              end
            end
            lpm_pkg::REQ_RENEW, lpm_pkg::REQ_RELEASE: begin
              state_next = (in_off < POOL_MAX_W) ? lpm_pkg::ST_MATCH : lpm_pkg::ST_RESP;
            end
            lpm_pkg::REQ_TICK: state_next = lpm_pkg::ST_TICK;
            default: state_next = lpm_pkg::ST_IDLE;
          endcase
        end
      end
      lpm_pkg::ST_MATCH: begin
        ram_waddr = slot;
        ram_wdata = '{hw_addr: hw, expiry: expiry_new};
        if (req == lpm_pkg::REQ_RENEW && hit) begin
          ram_we = 1'b1;
        end
        state_next = lpm_pkg::ST_RESP;
      end
      lpm_pkg::ST_DISC: begin
        if (32'(cnt) >= eff_size || !valid[cnt_idx]) begin
          state_next = lpm_pkg::ST_RESP;
        end
      end
      lpm_pkg::ST_TICK: begin
        ram_raddr = cnt_idx;
        if (cnt_done && !pend) begin
          state_next = lpm_pkg::ST_RESP;
        end
      end
      lpm_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = lpm_pkg::ST_IDLE;
        end
      end
      default: state_next = lpm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_start   <= lpm_pkg::RESET_RANGE_START;
      pool_size     <= lpm_pkg::RESET_POOL_SIZE;
      lease_len     <= lpm_pkg::RESET_LEASE_LEN;
      now           <= '0;
      valid         <= '0;
      pend          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          lpm_pkg::CFG_RANGE_START: range_start <= cfg_data;
          lpm_pkg::CFG_POOL_SIZE:   pool_size   <= cfg_data[4:0];
          lpm_pkg::CFG_LEASE_LEN:   lease_len   <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (state == lpm_pkg::ST_RESP && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        lpm_pkg::ST_IDLE: begin
          if (s_hs) begin
            req     <= s_axis_tuser;
            ip      <= in_ip;
            hw      <= in_hw;
            xid     <= in_xid;
            slot    <= in_idx;
            cnt     <= '0;
            pend    <= 1'b0;
            exp_cnt <= '0;
            res_ip  <= '0;
            case (s_axis_tuser)
              lpm_pkg::REQ_DISCOVER: res_status <= lpm_pkg::STS_NONE_FREE;
              lpm_pkg::REQ_REQUEST: begin
                if (in_off >= eff_size) begin
                  res_status <= lpm_pkg::STS_OUT_OF_RANGE;
                end else if (valid[in_idx]) begin
                  res_status <= lpm_pkg::STS_ALREADY;
                end else begin
                  res_status    <= lpm_pkg::STS_ACK_NEW;
                  res_ip        <= in_ip;
                  valid[in_idx] <= 1'b1;
                end
              end
              lpm_pkg::REQ_RENEW:   res_status <= lpm_pkg::STS_RENEW_MISS;
              lpm_pkg::REQ_RELEASE: res_status <= lpm_pkg::STS_RELEASE_MISS;
              lpm_pkg::REQ_TICK: begin
                res_status <= lpm_pkg::STS_TICK_DONE;
                if (now != 32'hFFFF_FFFF) begin
                  now <= now + 32'd1;
                end
              end
              default: ;
            endcase
          end
        end
        lpm_pkg::ST_MATCH: begin
          if (hit) begin
            if (req == lpm_pkg::REQ_RENEW) begin
              res_status <= lpm_pkg::STS_ACK_RENEW;
              res_ip     <= ip;
            end else begin
              res_status  <= lpm_pkg::STS_RELEASED;
              valid[slot] <= 1'b0;
            end
          end
        end
        lpm_pkg::ST_DISC: begin
          if (32'(cnt) < eff_size) begin
            if (!valid[cnt_idx]) begin
              res_status <= lpm_pkg::STS_OFFER;
              res_ip     <= range_start + 32'(cnt);
            end else begin
              cnt <= cnt + CNT_W'(1);
            end
          end
        end
        lpm_pkg::ST_TICK: begin
          // read slot cnt now, compare the slot read last cycle
          if (!cnt_done) begin
            pend     <= 1'b1;
            pend_idx <= cnt_idx;
            cnt      <= cnt + CNT_W'(1);
          end else begin
            pend <= 1'b0;
          end
          if (pend && valid[pend_idx] && (now > ram_rdata.expiry)) begin
            valid[pend_idx] <= 1'b0;
            exp_cnt         <= exp_cnt + CNT_W'(1);
          end
        end
        lpm_pkg::ST_RESP: begin
          if (out_free) begin
            m_axis_tuser  <= res_status;
            m_axis_tdata  <= {3'b000, 5'(exp_cnt), xid, res_ip};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int SLOTS = 16;
  // slowest request is a tick: one sweep over every slot
  localparam int SETTLE_CYCLES = SLOTS + 16;
  localparam int LONG_HOLD = 400;
  // request kinds the block drops without a reply
  localparam logic [2:0] REQ_RSVD_LO = 3'd5;
  localparam logic [2:0] REQ_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] addr;
    logic [31:0] xid;
    logic [4:0]  expired;
  } reply_t;

  class lease_reply_checker;
    logic [31:0] range_start;
    logic [4:0]  pool_size;
    logic [15:0] lease_len;
    bit          slot_valid[SLOTS];
    logic [47:0] slot_mac[SLOTS];
    logic [31:0] slot_expiry[SLOTS];
    logic [31:0] now_sec;
    reply_t      expected_replies[$];
    int          mismatch_count;

    function new();
      range_start = lpm_pkg::RESET_RANGE_START;
      pool_size = lpm_pkg::RESET_POOL_SIZE;
      lease_len = lpm_pkg::RESET_LEASE_LEN;
      now_sec = '0;
      mismatch_count = 0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i] = 1'b0;
        slot_mac[i] = '0;
        slot_expiry[i] = '0;
      end
    endfunction

    function void set_config(logic [1:0] index, logic [31:0] value);
      case (index)
        lpm_pkg::CFG_RANGE_START: range_start = value;
        lpm_pkg::CFG_POOL_SIZE:   pool_size = value[4:0];
        lpm_pkg::CFG_LEASE_LEN:   lease_len = value[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] new_expiry();
      logic [32:0] sum;
      sum = {1'b0, now_sec} + {17'd0, lease_len};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // renew and release look at all slots, not only the current pool size
    function bit lease_matches(logic [31:0] ip, logic [47:0] mac);
      logic [31:0] off;
      off = ip - range_start;
      if (off >= SLOTS) return 1'b0;
      return slot_valid[off[3:0]] && slot_mac[off[3:0]] == mac;
    endfunction

    function void note_request(logic [2:0] kind, logic [31:0] ip, logic [47:0] mac,
                               logic [31:0] xid);
      reply_t      r;
      logic [31:0] off;
      int          size;
      bit          found;
      size = (pool_size > SLOTS) ? SLOTS : pool_size;
      off = ip - range_start;
      r = '0;
      r.xid = xid;
      case (kind)
        lpm_pkg::REQ_DISCOVER: begin
          r.status = lpm_pkg::STS_NONE_FREE;
          found = 1'b0;
          for (int i = 0; i < size; i++) begin
            if (!found && !slot_valid[i]) begin
              found = 1'b1;
              r.status = lpm_pkg::STS_OFFER;
              r.addr = range_start + 32'(i);
            end
          end
        end
        lpm_pkg::REQ_REQUEST: begin
          if (off >= size) begin
            r.status = lpm_pkg::STS_OUT_OF_RANGE;
          end else if (slot_valid[off[3:0]]) begin
            r.status = lpm_pkg::STS_ALREADY;
          end else begin
            slot_valid[off[3:0]] = 1'b1;
            slot_mac[off[3:0]] = mac;
            slot_expiry[off[3:0]] = new_expiry();
            r.status = lpm_pkg::STS_ACK_NEW;
            r.addr = ip;
          end
        end
        lpm_pkg::REQ_RENEW: begin
          if (lease_matches(ip, mac)) begin
            slot_expiry[off[3:0]] = new_expiry();
            r.status = lpm_pkg::STS_ACK_RENEW;
            r.addr = ip;
          end else begin
            r.status = lpm_pkg::STS_RENEW_MISS;
          end
        end
        lpm_pkg::REQ_RELEASE: begin
          if (lease_matches(ip, mac)) begin
            slot_valid[off[3:0]] = 1'b0;
            r.status = lpm_pkg::STS_RELEASED;
          end else begin
            r.status = lpm_pkg::STS_RELEASE_MISS;
          end
        end
        lpm_pkg::REQ_TICK: begin
          if (now_sec != 32'hFFFF_FFFF) now_sec = now_sec + 32'd1;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && now_sec > slot_expiry[i]) begin
              slot_valid[i] = 1'b0;
              r.expired = r.expired + 5'd1;
            end
          end
          r.status = lpm_pkg::STS_TICK_DONE;
        end
        default: return;
      endcase
      expected_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: reply with nothing pending: status %0d addr %h xid %h expired %0d",
                   $realtime, got.status, got.addr, got.xid, got.expired);
        mismatch_count++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.status != want.status || got.addr != want.addr || got.xid != want.xid ||
          got.expired != want.expired) begin
        if (mismatch_count < 10)
          $display("%0t: reply mismatch: expected status %0d addr %h xid %h expired %0d,",
                   $realtime, want.status, want.addr, want.xid, want.expired,
                   " got status %0d addr %h xid %h expired %0d",
                   got.status, got.addr, got.xid, got.expired);
        mismatch_count++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [111:0]  s_axis_tdata;   // ip_addr, client_hw_addr, transaction_id
  logic [2:0]    s_axis_tuser;   // req_type
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [71:0]   m_axis_tdata;   // assigned_ip, echo_transaction_id, expired_count
  logic [3:0]    m_axis_tuser;   // status
  logic          cfg_we;
  logic [1:0]    cfg_addr;
  logic [31:0]   cfg_data;

  lease_reply_checker model = new();
  logic [47:0] macs[6];
  bit          calm = 1'b0;
  bit          hold_replies = 1'b0;

  ip_lease_pool_manager_core #(.POOL_MAX(SLOTS)) i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      model.check_reply({m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                         m_axis_tdata[68:64]});
  end

  // reply side: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_replies) begin
        hold_replies = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, calm ? 1 : 24)) @(posedge clk);
      end
    end
  end

  task automatic send_request(input logic [2:0] kind, input logic [31:0] ip,
                              input logic [47:0] mac, input logic [31:0] xid);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {xid, mac, ip};
    s_axis_tuser <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    model.note_request(kind, ip, mac, xid);
  endtask

  // dropped kinds give no reply, so let a full sweep pass after the queue empties
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (model.expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [31:0] start, input logic [4:0] size,
                              input logic [15:0] ltime);
    cfg_we <= 1'b1;
    cfg_addr <= lpm_pkg::CFG_RANGE_START;
    cfg_data <= start;
    @(posedge clk);
    cfg_addr <= lpm_pkg::CFG_POOL_SIZE;
    cfg_data <= {27'd0, size};
    @(posedge clk);
    cfg_addr <= lpm_pkg::CFG_LEASE_LEN;
    cfg_data <= {16'd0, ltime};
    @(posedge clk);
    cfg_we <= 1'b0;
    model.set_config(lpm_pkg::CFG_RANGE_START, start);
    model.set_config(lpm_pkg::CFG_POOL_SIZE, {27'd0, size});
    model.set_config(lpm_pkg::CFG_LEASE_LEN, {16'd0, ltime});
  endtask

  // addresses mostly sit in or just around the pool, clients come from a small set
  task automatic random_requests(input int count);
    int          done;
    int          pick;
    logic [2:0]  kind;
    logic [31:0] ip;
    logic [31:0] off;
    logic [47:0] mac;
    logic [63:0] wide;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) kind = lpm_pkg::REQ_DISCOVER;
      else if (pick < 44) kind = lpm_pkg::REQ_REQUEST;
      else if (pick < 60) kind = lpm_pkg::REQ_RENEW;
      else if (pick < 76) kind = lpm_pkg::REQ_RELEASE;
      else if (pick < 96) kind = lpm_pkg::REQ_TICK;
      else kind = 3'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
      pick = $urandom_range(0, 9);
      if (pick < 8) ip = model.range_start + $urandom_range(0, 17);
      else if (pick == 8) ip = $urandom;
      else ip = model.range_start - $urandom_range(1, 3);
      wide = {$urandom, $urandom};
      mac = ($urandom_range(0, 7) == 0) ? wide[47:0] : macs[$urandom_range(0, 5)];
      off = ip - model.range_start;
      if ((kind == lpm_pkg::REQ_RENEW || kind == lpm_pkg::REQ_RELEASE) && off < SLOTS &&
          model.slot_valid[off[3:0]] && $urandom_range(0, 3) != 0)
        mac = model.slot_mac[off[3:0]];
      send_request(kind, ip, mac, $urandom);
      if (kind <= lpm_pkg::REQ_TICK) done++;
    end
  endtask

  initial begin
    logic [31:0] base;
    logic [31:0] start;
    logic [63:0] wide;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= lpm_pkg::REQ_DISCOVER;
    cfg_we <= 1'b0;
    cfg_addr <= lpm_pkg::CFG_RANGE_START;
    cfg_data <= '0;
    macs[0] = '0;
    macs[1] = '1;
    for (int i = 2; i < 6; i++) begin
      wide = {$urandom, $urandom};
      macs[i] = wide[47:0];
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every request kind and every answer but none-free, under the reset setup
    base = lpm_pkg::RESET_RANGE_START;
    send_request(lpm_pkg::REQ_DISCOVER, 32'd0, macs[2], 32'h0000_0001);
    send_request(lpm_pkg::REQ_REQUEST, base, macs[2], 32'h0000_0002);
    send_request(lpm_pkg::REQ_REQUEST, base, macs[3], 32'h0000_0003);
    send_request(lpm_pkg::REQ_REQUEST, base + 10, macs[3], 32'h0000_0004);
    send_request(lpm_pkg::REQ_REQUEST, base - 1, macs[3], 32'h0000_0005);
    send_request(lpm_pkg::REQ_DISCOVER, 32'hFFFF_FFFF, macs[1], 32'h0000_0006);
    send_request(lpm_pkg::REQ_REQUEST, base + 9, macs[1], 32'hFFFF_FFFF);
    send_request(lpm_pkg::REQ_RENEW, base, macs[2], 32'h0000_0008);
    send_request(lpm_pkg::REQ_RENEW, base, macs[3], 32'h0000_0009);
    send_request(lpm_pkg::REQ_RENEW, base + 3, macs[2], 32'h0000_000A);
    send_request(lpm_pkg::REQ_RELEASE, base + 9, macs[0], 32'h0000_000B);
    send_request(lpm_pkg::REQ_RELEASE, base + 9, macs[1], 32'h0000_000C);
    send_request(lpm_pkg::REQ_RELEASE, base + 9, macs[1], 32'h0000_000D);
    for (int k = REQ_RSVD_LO; k <= REQ_RSVD_HI; k++)
      send_request(k[2:0], base + 1, macs[4], 32'hDEAD_0000 + k);
    send_request(lpm_pkg::REQ_REQUEST, 32'd0, macs[0], 32'd0);
    send_request(lpm_pkg::REQ_REQUEST, 32'hFFFF_FFFF, macs[1], 32'd0);
    send_request(lpm_pkg::REQ_RENEW, base + 12, macs[2], 32'h0000_0011);
    send_request(lpm_pkg::REQ_RELEASE, base + 12, macs[2], 32'h0000_0012);
    send_request(lpm_pkg::REQ_TICK, 32'd0, macs[0], 32'h0000_0013);
    random_requests(130);
    wait_drained();

    // full pool, then the same base shrunk: leases past the new size must stay
    start = $urandom;
    write_config(start, 5'd16, 16'd30);
    random_requests(100);
    hold_replies = 1'b1;
    random_requests(100);
    wait_drained();
    write_config(start, 5'd4, 16'd30);
    random_requests(150);
    wait_drained();

    // pool wrapping past the top of the address space
    write_config(32'hFFFF_FFF8, 5'd16, 16'd3);
    random_requests(200);
    wait_drained();

    // one-address pool, leases gone on the next tick
    write_config(32'd0, 5'd1, 16'd0);
    random_requests(120);
    wait_drained();

    // empty pool
    write_config($urandom, 5'd0, 16'd10);
    random_requests(60);
    wait_drained();

    // size above the slot count, longest lease
    write_config(32'hFFFF_FFFF, 5'd31, 16'hFFFF);
    random_requests(150);
    wait_drained();

    write_config($urandom, 5'd7, 16'd2);
    random_requests(150);
    calm = 1'b1;
    random_requests(150);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (model.mismatch_count == 0 && model.expected_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
